/* rtl/evp_pkg.sv */
// ----------------------------------------------------------------------------
// evp_pkg
// Shared types and constants for the 3x3 eigenvector-by-pivot-minor block.
// ----------------------------------------------------------------------------
`default_nettype none
package evp_pkg;

  localparam int unsigned NUM_ENTRIES = 9;
  localparam int unsigned NUM_MINORS  = 9;
  localparam int unsigned NUM_PRODS   = 18;
  localparam int unsigned PIVOT_W     = 4;
  localparam int unsigned THR_W       = 63;

  // column pair of the pivot minor
  localparam logic [1:0] COL_12 = 2'd0;
  localparam logic [1:0] COL_13 = 2'd1;
  localparam logic [1:0] COL_23 = 2'd2;

  // entries (a, d, b, c) of minor k = a*d - b*c, row-major entry numbers
  localparam int unsigned MINOR_ENT [36] = '{
    0, 4, 1, 3,
    0, 5, 2, 3,
    1, 5, 2, 4,
    0, 7, 1, 6,
    0, 8, 2, 6,
    1, 8, 2, 7,
    3, 7, 4, 6,
    3, 8, 5, 6,
    4, 8, 5, 7
  };

  // sideband that travels with an item through the dividers
  typedef struct packed {
    logic               found;
    logic [PIVOT_W-1:0] idx;
    logic [1:0]         col;
  } evp_side_t;

endpackage
`default_nettype wire

/* rtl/evp_mult.sv */
// ----------------------------------------------------------------------------
// evp_mult
// Shifts the diagonal by the eigenvalue, then forms the 18 minor products.
// ----------------------------------------------------------------------------
`default_nettype none
module evp_mult #(
  parameter int unsigned IN_WIDTH = 32
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              en,
  input  wire                              in_valid,
  input  wire [10*IN_WIDTH-1:0]            in_data,
  output logic                             prod_valid_r,
  output logic signed [2*IN_WIDTH+1:0]     prod_r [evp_pkg::NUM_PRODS]
);

  localparam int unsigned AW = IN_WIDTH + 1;
  localparam int unsigned PW = 2 * AW;

  logic signed [AW-1:0] ent_r   [evp_pkg::NUM_ENTRIES];
  logic signed [AW-1:0] ent_nxt [evp_pkg::NUM_ENTRIES];
  logic                 ent_valid_r;
  logic signed [IN_WIDTH-1:0] eig;

  assign eig = in_data[9*IN_WIDTH +: IN_WIDTH];

  // shifted matrix, one bit wider
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      if (i == 0 || i == 4 || i == 8) begin
        ent_nxt[i] = $signed({in_data[i*IN_WIDTH+IN_WIDTH-1], in_data[i*IN_WIDTH +: IN_WIDTH]})
                     - $signed({eig[IN_WIDTH-1], eig});
      end else begin
        ent_nxt[i] = $signed({in_data[i*IN_WIDTH+IN_WIDTH-1], in_data[i*IN_WIDTH +: IN_WIDTH]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r  <= 1'b0;
      prod_valid_r <= 1'b0;
    end else if (en) begin
      ent_valid_r  <= in_valid;
      prod_valid_r <= ent_valid_r;
    end
  end

  // entries, then products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) ent_r[i] <= ent_nxt[i];
      for (int k = 0; k < 9; k++) begin
        prod_r[2*k]   <= PW'(ent_r[evp_pkg::MINOR_ENT[4*k]]   * ent_r[evp_pkg::MINOR_ENT[4*k+1]]);
        prod_r[2*k+1] <= PW'(ent_r[evp_pkg::MINOR_ENT[4*k+2]] * ent_r[evp_pkg::MINOR_ENT[4*k+3]]);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/evp_pivot.sv */
// ----------------------------------------------------------------------------
// evp_pivot
// Forms minors and magnitudes, finds the largest, checks the threshold and
// picks the two numerators for the dividers.
// ----------------------------------------------------------------------------
`default_nettype none
module evp_pivot #(
  parameter int unsigned IN_WIDTH = 32
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   en,
  input  wire                                   prod_valid,
  input  wire signed [2*IN_WIDTH+1:0]           prod [evp_pkg::NUM_PRODS],
  input  wire [evp_pkg::THR_W-1:0]              thr,
  output logic                                  sel_valid_r,
  output logic [2*IN_WIDTH+2:0]                 num0_r,
  output logic [2*IN_WIDTH+2:0]                 num1_r,
  output logic [2*IN_WIDTH+2:0]                 den_r,
  output logic                                  neg0_r,
  output logic                                  neg1_r,
  output evp_pkg::evp_side_t                    side_r
);

  localparam int unsigned PW = 2 * IN_WIDTH + 2;
  localparam int unsigned MW = PW + 1;

  logic signed [MW-1:0] mn_r  [evp_pkg::NUM_MINORS];
  logic [MW-1:0]        mag_r [evp_pkg::NUM_MINORS];
  logic [MW-1:0]        mag2_r [evp_pkg::NUM_MINORS];
  logic [MW-1:0]        mag3_r [evp_pkg::NUM_MINORS];
  logic [8:0]           sgn_r, sgn2_r, sgn3_r;
  logic [MW-1:0]        gmag_r [3];
  logic [MW-1:0]        gmag_nxt [3];
  logic [evp_pkg::PIVOT_W-1:0] gidx_r [3];
  logic [evp_pkg::PIVOT_W-1:0] gidx_nxt [3];
  logic [MW-1:0]        bmag_r, bmag_nxt;
  logic [evp_pkg::PIVOT_W-1:0] bidx_r, bidx_nxt;
  logic                 v_mn_r, v_mag_r, v_grp_r, v_best_r;
  logic [evp_pkg::PIVOT_W-1:0] n0, n1;
  logic                 ng0, ng1;
  logic [1:0]           col;
  logic                 found;

  // group winners, lowest index on ties
  always_comb begin
    for (int g = 0; g < 3; g++) begin
      gmag_nxt[g] = mag_r[3*g];
      gidx_nxt[g] = evp_pkg::PIVOT_W'(3*g);
      if (mag_r[3*g+1] > gmag_nxt[g]) begin
        gmag_nxt[g] = mag_r[3*g+1];
        gidx_nxt[g] = evp_pkg::PIVOT_W'(3*g+1);
      end
      if (mag_r[3*g+2] > gmag_nxt[g]) begin
        gmag_nxt[g] = mag_r[3*g+2];
        gidx_nxt[g] = evp_pkg::PIVOT_W'(3*g+2);
      end
    end
  end

  // overall winner
  always_comb begin
    bmag_nxt = gmag_r[0];
    bidx_nxt = gidx_r[0];
    if (gmag_r[1] > bmag_nxt) begin
      bmag_nxt = gmag_r[1];
      bidx_nxt = gidx_r[1];
    end
    if (gmag_r[2] > bmag_nxt) begin
      bmag_nxt = gmag_r[2];
      bidx_nxt = gidx_r[2];
    end
  end

  // numerator choice from the pivot's column pair
  always_comb begin
    case (bidx_r)
      4'd0, 4'd3, 4'd6: col = evp_pkg::COL_12;
      4'd1, 4'd4, 4'd7: col = evp_pkg::COL_13;
      default:          col = evp_pkg::COL_23;
    endcase
    case (col)
      evp_pkg::COL_12: begin
        n0 = bidx_r + 4'd2; ng0 = 1'b0;
        n1 = bidx_r + 4'd1; ng1 = 1'b1;
      end
      evp_pkg::COL_13: begin
        n0 = bidx_r + 4'd1; ng0 = 1'b1;
        n1 = bidx_r - 4'd1; ng1 = 1'b1;
      end
      default: begin
        n0 = bidx_r - 4'd1; ng0 = 1'b1;
        n1 = bidx_r - 4'd2; ng1 = 1'b0;
      end
    endcase
    found = ({{evp_pkg::THR_W{1'b0}}, bmag_r} >= {{MW{1'b0}}, thr}) && (bmag_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_mn_r      <= 1'b0;
      v_mag_r     <= 1'b0;
      v_grp_r     <= 1'b0;
      v_best_r    <= 1'b0;
      sel_valid_r <= 1'b0;
    end else if (en) begin
      v_mn_r      <= prod_valid;
      v_mag_r     <= v_mn_r;
      v_grp_r     <= v_mag_r;
      v_best_r    <= v_grp_r;
      sel_valid_r <= v_best_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // minors
      for (int k = 0; k < 9; k++) begin
        mn_r[k] <= $signed({prod[2*k][PW-1], prod[2*k]})
                   - $signed({prod[2*k+1][PW-1], prod[2*k+1]});
      end
      // magnitudes
      for (int k = 0; k < 9; k++) begin
        mag_r[k] <= mn_r[k][MW-1] ? MW'(-mn_r[k]) : MW'(mn_r[k]);
        sgn_r[k] <= mn_r[k][MW-1];
      end
      // group compare
      gmag_r <= gmag_nxt;
      gidx_r <= gidx_nxt;
      mag2_r <= mag_r;
      sgn2_r <= sgn_r;
      // final compare
      bmag_r <= bmag_nxt;
      bidx_r <= bidx_nxt;
      mag3_r <= mag2_r;
      sgn3_r <= sgn2_r;
      // divider operands
      num0_r       <= mag3_r[n0];
      num1_r       <= mag3_r[n1];
      den_r        <= bmag_r;
      neg0_r       <= sgn3_r[n0] ^ sgn3_r[bidx_r] ^ ng0;
      neg1_r       <= sgn3_r[n1] ^ sgn3_r[bidx_r] ^ ng1;
      side_r.found <= found;
      side_r.idx   <= bidx_r;
      side_r.col   <= col;
    end
  end

endmodule
`default_nettype wire

/* rtl/evp_div.sv */
// ----------------------------------------------------------------------------
// evp_div
// Pipelined restoring divider, one quotient bit per stage. Needs num <= den.
// ----------------------------------------------------------------------------
`default_nettype none
module evp_div #(
  parameter int unsigned MW    = 67,
  parameter int unsigned STEPS = 31,
  parameter int unsigned TW    = 1
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               en,
  input  wire               in_valid,
  input  wire [MW-1:0]      num,
  input  wire [MW-1:0]      den,
  input  wire [TW-1:0]      tag,
  output logic              out_valid,
  output logic [STEPS-1:0]  quo,
  output logic [TW-1:0]     out_tag
);

  logic [MW:0]      rem_r   [STEPS];
  logic [MW:0]      rem_nxt [STEPS];
  logic [STEPS-1:0] q_r     [STEPS];
  logic [STEPS-1:0] q_nxt   [STEPS];
  logic [MW-1:0]    d_r     [STEPS];
  logic [TW-1:0]    tag_r   [STEPS];
  logic [STEPS-1:0] v_r;
  logic [MW:0]      rin;
  logic [STEPS-1:0] qin;

  // one compare-subtract per stage
  always_comb begin
    for (int s = 0; s < STEPS; s++) begin
      if (s == 0) begin
        rin = {1'b0, num};
        qin = '0;
        if (rin >= {1'b0, den}) begin
          rem_nxt[s] = rin - {1'b0, den};
          q_nxt[s]   = qin | STEPS'(1);
        end else begin
          rem_nxt[s] = rin;
          q_nxt[s]   = qin;
        end
      end else begin
        rin = {rem_r[s-1][MW-1:0], 1'b0};
        qin = {q_r[s-1][STEPS-2:0], 1'b0};
        if (rin >= {1'b0, d_r[s-1]}) begin
          rem_nxt[s] = rin - {1'b0, d_r[s-1]};
          q_nxt[s]   = qin | STEPS'(1);
        end else begin
          rem_nxt[s] = rin;
          q_nxt[s]   = qin;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < STEPS; s++) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
      end
      d_r[0]   <= den;
      tag_r[0] <= tag;
      for (int s = 1; s < STEPS; s++) begin
        d_r[s]   <= d_r[s-1];
        tag_r[s] <= tag_r[s-1];
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign quo       = q_r[STEPS-1];
  assign out_tag   = tag_r[STEPS-1];

endmodule
`default_nettype wire

/* rtl/eigenvector_3x3_from_eigenvalue_top.sv */
// ----------------------------------------------------------------------------
// eigenvector_3x3_from_eigenvalue_top
// Eigenvector of a 3x3 Q16.16 matrix for a given eigenvalue, by pivot minor.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the pipeline is not held, and returns one
// result per request, in order. Registered steps, in order: the diagonal
// shift, the products, the minors, the magnitudes, the two-level pivot
// search, the operand select, the bit-per-stage dividers and the output
// register. The whole pipeline advances together; it holds when the output
// register is full and not taken.
// ----------------------------------------------------------------------------
`default_nettype none
module eigenvector_3x3_from_eigenvalue_top #(
  parameter int unsigned IN_WIDTH      = 32,
  parameter int unsigned OUT_FRAC_BITS = 30
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_wr_en,
  input  wire [evp_pkg::THR_W-1:0]              cfg_wr_data,  // min_pivot_magnitude
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  // m11, m12, m13, m21, m22, m23, m31, m32, m33, eigenvalue, zero pad
  input  wire [((10*IN_WIDTH+7)/8)*8-1:0]       in_tdata,
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  // vec0, vec1, vec2, found, pivot_index, zero pad
  output logic [((3*(OUT_FRAC_BITS+2)+5+7)/8)*8-1:0] out_tdata
);

  localparam int unsigned MW    = 2 * IN_WIDTH + 3;
  localparam int unsigned VW    = OUT_FRAC_BITS + 2;
  localparam int unsigned STEPS = OUT_FRAC_BITS + 1;
  localparam int unsigned OW    = ((3 * VW + 5 + 7) / 8) * 8;
  localparam int unsigned SW    = $bits(evp_pkg::evp_side_t);

  logic                          en;
  logic [evp_pkg::THR_W-1:0]     thr_r;
  logic                          prod_valid;
  logic signed [2*IN_WIDTH+1:0]  prod [evp_pkg::NUM_PRODS];
  logic                          sel_valid;
  logic [MW-1:0]                 num0, num1, den;
  logic                          neg0, neg1;
  evp_pkg::evp_side_t            side, dside;
  logic                          dv0, dv1;
  logic [STEPS-1:0]              q0, q1;
  logic                          dneg0, dneg1;
  logic [SW:0]                   tag0;
  logic [VW-1:0]                 r0, r1, one;
  logic [VW-1:0]                 vec_nxt [3];
  logic                          out_valid_r;
  logic [OW-1:0]                 out_data_r;

  assign en        = out_tready || !out_valid_r;
  assign in_tready = en;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= evp_pkg::THR_W'(1);
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  evp_mult #(.IN_WIDTH(IN_WIDTH)) u_mult (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_tvalid),
    .in_data      (in_tdata[10*IN_WIDTH-1:0]),
    .prod_valid_r (prod_valid),
    .prod_r       (prod)
  );

  evp_pivot #(.IN_WIDTH(IN_WIDTH)) u_pivot (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .prod_valid  (prod_valid),
    .prod        (prod),
    .thr         (thr_r),
    .sel_valid_r (sel_valid),
    .num0_r      (num0),
    .num1_r      (num1),
    .den_r       (den),
    .neg0_r      (neg0),
    .neg1_r      (neg1),
    .side_r      (side)
  );

  evp_div #(.MW(MW), .STEPS(STEPS), .TW(SW + 1)) u_div0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sel_valid),
    .num       (num0),
    .den       (den),
    .tag       ({side, neg0}),
    .out_valid (dv0),
    .quo       (q0),
    .out_tag   (tag0)
  );

  evp_div #(.MW(MW), .STEPS(STEPS), .TW(1)) u_div1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sel_valid),
    .num       (num1),
    .den       (den),
    .tag       (neg1),
    .out_valid (dv1),
    .quo       (q1),
    .out_tag   (dneg1)
  );

  assign dside = tag0[SW:1];
  assign dneg0 = tag0[0];

  // signed ratios and component placement
  always_comb begin
    one = VW'(1) << OUT_FRAC_BITS;
    r0  = dneg0 ? VW'(-{1'b0, q0}) : {1'b0, q0};
    r1  = dneg1 ? VW'(-{1'b0, q1}) : {1'b0, q1};
    case (dside.col)
      evp_pkg::COL_12: begin
        vec_nxt[0] = r0; vec_nxt[1] = r1;  vec_nxt[2] = one;
      end
      evp_pkg::COL_13: begin
        vec_nxt[0] = r0; vec_nxt[1] = one; vec_nxt[2] = r1;
      end
      default: begin
        vec_nxt[0] = one; vec_nxt[1] = r0; vec_nxt[2] = r1;
      end
    endcase
    if (!dside.found) begin
      vec_nxt[0] = '0;
      vec_nxt[1] = '0;
      vec_nxt[2] = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv0 & dv1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= OW'({(dside.found ? dside.idx : evp_pkg::PIVOT_W'(0)), dside.found,
                         vec_nxt[2], vec_nxt[1], vec_nxt[0]});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Randomized streaming test of the 3x3 eigenvector-by-pivot-minor block.
// Requests are predicted in a local model of the minor search and the
// Q2.30 ratio divider; results are checked in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

// Expected-result store and in-order checker
class eigvec_scoreboard;
  logic [100:0] pending_q[$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned found_cnt;

  function new();
    mismatches = 0;
    checked = 0;
    found_cnt = 0;
  endfunction

  function void note_request(logic [100:0] want);
    pending_q.push_back(want);
  endfunction

  function void check_result(logic [103:0] got);
    logic [100:0] want;
    logic [100:0] g;
    g = got[100:0];
    checked++;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", g);
      return;
    end
    want = pending_q.pop_front();
    if (want[96]) found_cnt++;
    if (g[31:0] !== want[31:0] || g[63:32] !== want[63:32] ||
        g[95:64] !== want[95:64] || g[96] !== want[96] ||
        g[100:97] !== want[100:97] || got[103:101] !== 3'b0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch #%0d: vec0 %h/%h vec1 %h/%h vec2 %h/%h found %b/%b piv %0d/%0d",
                 checked, want[31:0], g[31:0], want[63:32], g[63:32],
                 want[95:64], g[95:64], want[96], g[96], want[100:97], g[100:97]);
    end
  endfunction
endclass

module tb;
  localparam int unsigned WATCHDOG = 20000;
  localparam int unsigned DRAIN    = 60;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [62:0]  cfg_wr_data = '0;
  logic         in_tvalid = 1'b0;
  wire          in_tready;
  logic [319:0] in_tdata = '0;
  wire          out_tvalid;
  logic         out_tready = 1'b0;
  wire  [103:0] out_tdata;

  eigenvector_3x3_from_eigenvalue_top uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  eigvec_scoreboard sb = new();
  logic [62:0] pivot_floor = 63'd1;
  int unsigned idle_cycles = 0;
  bit          timed_out = 1'b0;
  bit          hold_off = 1'b0;
  int unsigned sent = 0;

  // signed 128-bit magnitude helper
  function automatic logic [127:0] mag128(logic signed [127:0] x);
    return x[127] ? 128'(-x) : 128'(x);
  endfunction

  // ratio num/den in Q2.30, truncated toward zero, extra negation
  function automatic logic [31:0] minor_ratio(logic signed [127:0] num, bit negate,
                                              logic signed [127:0] den);
    logic [127:0] r, d;
    logic [63:0]  q;
    bit neg;
    neg = (num[127] != den[127]) != negate;
    r = mag128(num);
    d = mag128(den);
    q = 0;
    if (r >= d) begin
      q = 1;
      r = r - d;
    end
    for (int i = 0; i < 30; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    if (num[127] && q == 0) neg = 1'b0;
    if (neg) q = -q;
    return q[31:0];
  endfunction

  // expected {pivot, found, vec2, vec1, vec0} for one request
  function automatic logic [100:0] predict_eigvec(logic [319:0] req, logic [62:0] thr);
    logic signed [63:0]  a[9];
    logic signed [63:0]  ev;
    logic signed [127:0] mn[9];
    logic [127:0]        amax;
    logic [31:0]         v0, v1, v2;
    logic [31:0]         one_q;
    int                  best, g, ent[36];
    ent = '{0,4,1,3, 0,5,2,3, 1,5,2,4, 0,7,1,6, 0,8,2,6, 1,8,2,7,
            3,7,4,6, 3,8,5,6, 4,8,5,7};
    one_q = 32'h4000_0000;
    ev = 64'(signed'(req[319:288]));
    for (int i = 0; i < 9; i++) a[i] = 64'(signed'(req[i*32 +: 32]));
    a[0] -= ev;
    a[4] -= ev;
    a[8] -= ev;
    for (int k = 0; k < 9; k++)
      mn[k] = 128'(a[ent[4*k]]) * 128'(a[ent[4*k+1]])
            - 128'(a[ent[4*k+2]]) * 128'(a[ent[4*k+3]]);
    best = 0;
    amax = mag128(mn[0]);
    for (int k = 1; k < 9; k++)
      if (amax < mag128(mn[k])) begin
        amax = mag128(mn[k]);
        best = k;
      end
    if (amax < {65'd0, thr} || amax == 0) return '0;
    g = (best / 3) * 3;
    case (best % 3)
      0: begin
        v0 = minor_ratio(mn[g+2], 1'b0, mn[best]);
        v1 = minor_ratio(mn[g+1], 1'b1, mn[best]);
        v2 = one_q;
      end
      1: begin
        v0 = minor_ratio(mn[g+2], 1'b1, mn[best]);
        v1 = one_q;
        v2 = minor_ratio(mn[g], 1'b1, mn[best]);
      end
      default: begin
        v0 = one_q;
        v1 = minor_ratio(mn[g+1], 1'b1, mn[best]);
        v2 = minor_ratio(mn[g], 1'b0, mn[best]);
      end
    endcase
    return {4'(best), 1'b1, v2, v1, v0};
  endfunction

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
  endfunction

  // random entry: mostly small values, sometimes extremes or full range
  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: return $urandom();
      4: return 32'(signed'($urandom_range(0, 8)) - 4) << 16;
      default: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
    endcase
  endfunction

  // singular-ish matrix: rank-one term plus eigenvalue on the diagonal, or all random entries
  function automatic logic [319:0] rand_request();
    logic [319:0] r;
    logic signed [31:0] u[3], w[3], lam;
    if ($urandom_range(0, 2) == 0) begin
      for (int i = 0; i < 10; i++) r[i*32 +: 32] = rand_entry();
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      u[i] = $signed($urandom_range(0, 512)) - 256;
      w[i] = $signed($urandom_range(0, 512)) - 256;
    end
    lam = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        r[(3*i+j)*32 +: 32] = 32'(u[i] * w[j] * 16) + ((i == j) ? lam : 32'sd0);
    r[319:288] = lam;
    return r;
  endfunction

  // offer one request and hold it until taken; valid drops only across a gap
  task automatic send_request(logic [319:0] req);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= req;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_request(predict_eigvec(req, pivot_floor));
    sent++;
    @(negedge clk);
  endtask

  // wait for every expected result, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0 && !timed_out) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_floor(logic [62:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    pivot_floor = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // result side: random stalls, one long hold-off on request
  always @(negedge clk) begin
    if (hold_off) begin
      out_tready <= 1'b0;
      repeat (300) @(negedge clk);
      hold_off = 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      repeat (gap_len()) @(negedge clk);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result check and idle watchdog
  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(out_tdata);
    if (rst_n && !(out_tvalid && out_tready) && !(in_tvalid && in_tready))
      idle_cycles++;
    else
      idle_cycles = 0;
    if (idle_cycles >= WATCHDOG) begin
      timed_out = 1'b1;
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [319:0] r;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero matrix, extremes, identity, each pivot position
    send_request('0);
    send_request({10{32'h8000_0000}});
    send_request({10{32'h7fff_ffff}});
    send_request({32'h8000_0000, {9{32'h7fff_ffff}}});
    send_request({32'h7fff_ffff, {9{32'h8000_0000}}});
    send_request({32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0,
                  32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000});
    for (int k = 0; k < 9; k++) begin
      r = '0;
      r[k*32 +: 32] = 32'h0003_0000;
      r[((k+4)%9)*32 +: 32] = 32'hfffe_0000;
      r[((k+5)%9)*32 +: 32] = 32'h0001_0000;
      send_request(r);
    end
    for (int i = 0; i < 6; i++) send_request({$urandom(), {9{$urandom()}}} ^ 320'(1) << i);
    drain();

    // threshold sweep, including zero and the top value
    write_floor(63'd0);
    for (int i = 0; i < 200; i++) send_request(rand_request());
    drain();
    write_floor(63'h4000_0000_0000_0000);
    for (int i = 0; i < 150; i++) send_request(rand_request());
    drain();
    write_floor(63'h7fff_ffff_ffff_ffff);
    for (int i = 0; i < 50; i++) send_request(rand_request());
    drain();
    write_floor(63'h0000_0100_0000_0000);
    hold_off = 1'b1;
    for (int i = 0; i < 300; i++) send_request(rand_request());
    drain();
    write_floor(63'd1);
    for (int i = 0; i < 380; i++) send_request(rand_request());
    drain();

    $display("covered %0d requests over five pivot thresholds; %0d results checked,",
             sent, sb.checked);
    $display("%0d with a pivot found, one long output stall included", sb.found_cnt);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

`default_nettype wire

/* eigenvector_3x3_from_eigenvalue_top.f */
rtl/evp_pkg.sv
rtl/evp_mult.sv
rtl/evp_pivot.sv
rtl/evp_div.sv
rtl/eigenvector_3x3_from_eigenvalue_top.sv
tb/tb.sv
